FILE: rtl/jts_pkg.sv
// Shared types, character codes and literal tables for the JSON token scanner.
// Depends on nothing; every other file in rtl/ imports it.
`timescale 1ns / 1ps

package jts_pkg;

    // Default width of the internal byte position counter.
    localparam int unsigned POS_WIDTH_DEFAULT = 16;

    // Width of the positions that appear in a result.
    localparam int unsigned TOKEN_POS_W = 16;

    // Depth of the result queue; must be a power of two and at least two.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Scanner modes.
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_NUMBER  = 2'd2,
        MODE_LITERAL = 2'd3
    } scan_mode_t;

    // Literal kinds; the fourth code is checked as null.
    localparam logic [1:0] LIT_TRUE  = 2'd0;
    localparam logic [1:0] LIT_FALSE = 2'd1;
    localparam logic [1:0] LIT_NULL  = 2'd2;

    // Token kinds.
    localparam logic [3:0] TOK_LBRACE   = 4'd0;
    localparam logic [3:0] TOK_RBRACE   = 4'd1;
    localparam logic [3:0] TOK_LBRACKET = 4'd2;
    localparam logic [3:0] TOK_RBRACKET = 4'd3;
    localparam logic [3:0] TOK_COLON    = 4'd4;
    localparam logic [3:0] TOK_COMMA    = 4'd5;
    localparam logic [3:0] TOK_STRING   = 4'd6;
    localparam logic [3:0] TOK_NUMBER   = 4'd7;
    localparam logic [3:0] TOK_BOOL     = 4'd8;
    localparam logic [3:0] TOK_NULL     = 4'd9;

    // Error codes.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_BOOL = 3'd1;
    localparam logic [2:0] ERR_BAD_NULL = 3'd2;
    localparam logic [2:0] ERR_UNTERM   = 3'd3;
    localparam logic [2:0] ERR_UNEXPECT = 3'd4;

    // Character codes.
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_E  = 8'h65;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_LOWER_L  = 8'h6C;
    localparam logic [7:0] CH_LOWER_N  = 8'h6E;
    localparam logic [7:0] CH_LOWER_R  = 8'h72;
    localparam logic [7:0] CH_LOWER_S  = 8'h73;
    localparam logic [7:0] CH_LOWER_T  = 8'h74;
    localparam logic [7:0] CH_LOWER_U  = 8'h75;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    // One result item.
    typedef struct packed {
        logic [3:0]             kind;
        logic [TOKEN_POS_W-1:0] start_pos;
        logic [TOKEN_POS_W-1:0] end_pos;
        logic [2:0]             err;
        logic                   last;
    } token_t;

    // Results produced by one byte, handed from the scanner to the queue.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    // Letter of a literal at a given index; zero past its end.
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] ch;
        ch = CH_NUL;
        case (kind)
            LIT_TRUE:
            begin
                case (idx)
                    3'd0: ch = CH_LOWER_T;
                    3'd1: ch = CH_LOWER_R;
                    3'd2: ch = CH_LOWER_U;
                    3'd3: ch = CH_LOWER_E;
                    default: ch = CH_NUL;
                endcase
            end
            LIT_FALSE:
            begin
                case (idx)
                    3'd0: ch = CH_LOWER_F;
                    3'd1: ch = CH_LOWER_A;
                    3'd2: ch = CH_LOWER_L;
                    3'd3: ch = CH_LOWER_S;
                    3'd4: ch = CH_LOWER_E;
                    default: ch = CH_NUL;
                endcase
            end
            default:
            begin
                case (idx)
                    3'd0: ch = CH_LOWER_N;
                    3'd1: ch = CH_LOWER_U;
                    3'd2: ch = CH_LOWER_L;
                    3'd3: ch = CH_LOWER_L;
                    default: ch = CH_NUL;
                endcase
            end
        endcase
        return ch;
    endfunction

    // Number of letters in a literal.
    function automatic logic [3:0] lit_len(input logic [1:0] kind);
        logic [3:0] len;
        len = (kind == LIT_FALSE) ? 4'd5 : 4'd4;
        return len;
    endfunction

    // True for a digit or a decimal point.
    function automatic logic is_numeric(input logic [7:0] ch);
        logic hit;
        hit = ch inside {[CH_ZERO:CH_NINE], CH_DOT};
        return hit;
    endfunction

endpackage

FILE: rtl/jts_scan_core.sv
// Scanner state machine: one held byte per cycle while go is high, up to two results.
// Depends on jts_pkg for the mode enum, result types and literal tables.
`timescale 1ns / 1ps

module jts_scan_core #(
    parameter int unsigned POS_WIDTH = jts_pkg::POS_WIDTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           go,
    input  logic [7:0]     text_byte,
    input  logic           end_of_text,
    output jts_pkg::push_t push
);

    import jts_pkg::*;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    scan_mode_t           mode_reg,     mode_next;
    logic [POS_WIDTH-1:0] pos_reg,      pos_next;
    logic [POS_WIDTH-1:0] start_reg,    start_next;
    logic [1:0]           lit_kind_reg, lit_kind_next;
    logic [2:0]           lit_cnt_reg,  lit_cnt_next;
    logic                 halted_reg,   halted_next;

    // Idle-mode decode of the current byte.
    logic       idle_emit;
    token_t     idle_tok;
    scan_mode_t idle_mode;
    logic       idle_halt;
    logic       idle_take_start;
    logic       idle_take_lit;
    logic [1:0] idle_lit_kind;

    // Literal compare.
    logic       lit_match;
    logic [3:0] lit_cnt_inc;
    logic       lit_done;
    logic [2:0] lit_err;
    logic [3:0] lit_tok;

    logic [TOKEN_POS_W-1:0] p_out;
    logic [TOKEN_POS_W-1:0] p_prev_out;
    logic [TOKEN_POS_W-1:0] start_out;

    token_t     r0;
    token_t     r1;
    logic [1:0] n;

    // Low bits of a position as they appear in a result.
    function automatic logic [TOKEN_POS_W-1:0] to_out(input logic [POS_WIDTH-1:0] v);
        logic [POS_WIDTH+TOKEN_POS_W-1:0] wide;
        wide = {{TOKEN_POS_W{1'b0}}, v};
        return wide[TOKEN_POS_W-1:0];
    endfunction

    function automatic token_t mk(input logic [3:0] kind, input logic [TOKEN_POS_W-1:0] s,
                                  input logic [TOKEN_POS_W-1:0] e, input logic [2:0] err);
        token_t t;
        t.kind      = kind;
        t.start_pos = s;
        t.end_pos   = e;
        t.err       = err;
        t.last      = 1'b0;
        return t;
    endfunction

    assign p_out      = to_out(pos_reg);
    assign p_prev_out = to_out(pos_reg - 1'b1);
    assign start_out  = to_out(start_reg);

    // Literal letter check against the stored kind and match count.
    assign lit_match   = (text_byte == lit_char(lit_kind_reg, lit_cnt_reg));
    assign lit_cnt_inc = {1'b0, lit_cnt_reg} + 4'd1;
    assign lit_done    = (lit_cnt_inc >= lit_len(lit_kind_reg));
    assign lit_err     = (lit_kind_reg == LIT_TRUE || lit_kind_reg == LIT_FALSE)
                         ? ERR_BAD_BOOL : ERR_BAD_NULL;
    assign lit_tok     = (lit_kind_reg == LIT_TRUE || lit_kind_reg == LIT_FALSE)
                         ? TOK_BOOL : TOK_NULL;

    // Decode of a byte seen in idle mode.
    always_comb
    begin
        idle_emit       = 1'b0;
        idle_tok        = '0;
        idle_mode       = MODE_IDLE;
        idle_halt       = 1'b0;
        idle_take_start = 1'b0;
        idle_take_lit   = 1'b0;
        idle_lit_kind   = LIT_TRUE;
        case (text_byte)
            CH_TAB, CH_LF, CH_CR, CH_SPACE, CH_NUL:
            begin
                idle_emit = 1'b0;
            end
            CH_LBRACE:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(TOK_LBRACE, p_out, p_out, ERR_NONE);
            end
            CH_RBRACE:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(TOK_RBRACE, p_out, p_out, ERR_NONE);
            end
            CH_LBRACKET:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(TOK_LBRACKET, p_out, p_out, ERR_NONE);
            end
            CH_RBRACKET:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(TOK_RBRACKET, p_out, p_out, ERR_NONE);
            end
            CH_COLON:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(TOK_COLON, p_out, p_out, ERR_NONE);
            end
            CH_COMMA:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(TOK_COMMA, p_out, p_out, ERR_NONE);
            end
            CH_QUOTE:
            begin
                if (end_of_text)
                begin
                    idle_emit = 1'b1;
                    idle_halt = 1'b1;
                    idle_tok  = mk(TOK_LBRACE, p_out, p_out, ERR_UNTERM);
                end
                else
                begin
                    idle_take_start = 1'b1;
                    idle_mode       = MODE_STRING;
                end
            end
            CH_LOWER_T, CH_LOWER_F, CH_LOWER_N:
            begin
                if (end_of_text)
                begin
                    idle_emit = 1'b1;
                    idle_halt = 1'b1;
                    idle_tok  = mk(TOK_LBRACE, p_out, p_out, ERR_UNTERM);
                end
                else
                begin
                    idle_take_start = 1'b1;
                    idle_take_lit   = 1'b1;
                    idle_mode       = MODE_LITERAL;
                    idle_lit_kind   = (text_byte == CH_LOWER_T) ? LIT_TRUE :
                                      (text_byte == CH_LOWER_F) ? LIT_FALSE : LIT_NULL;
                end
            end
            default:
            begin
                if (is_numeric(text_byte))
                begin
                    if (end_of_text)
                    begin
                        idle_emit = 1'b1;
                        idle_tok  = mk(TOK_NUMBER, p_out, p_out, ERR_NONE);
                    end
                    else
                    begin
                        idle_take_start = 1'b1;
                        idle_mode       = MODE_NUMBER;
                    end
                end
                else
                begin
                    idle_emit = 1'b1;
                    idle_halt = 1'b1;
                    idle_tok  = mk(TOK_LBRACE, p_out, p_out, ERR_UNEXPECT);
                end
            end
        endcase
    end

    // Next state of the scanner.
    always_comb
    begin
        mode_next     = mode_reg;
        start_next    = start_reg;
        lit_kind_next = lit_kind_reg;
        lit_cnt_next  = lit_cnt_reg;
        halted_next   = halted_reg;
        if (!halted_reg)
        begin
            case (mode_reg)
                MODE_STRING:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (end_of_text)
                    begin
                        mode_next   = MODE_IDLE;
                        halted_next = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_numeric(text_byte))
                    begin
                        if (end_of_text)
                        begin
                            mode_next = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        // The ending byte is scanned again as a fresh byte.
                        mode_next   = idle_mode;
                        halted_next = idle_halt;
                        if (idle_take_start)
                        begin
                            start_next = pos_reg;
                        end
                        if (idle_take_lit)
                        begin
                            lit_kind_next = idle_lit_kind;
                            lit_cnt_next  = 3'd1;
                        end
                    end
                end
                MODE_LITERAL:
                begin
                    if (!lit_match)
                    begin
                        mode_next   = MODE_IDLE;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        lit_cnt_next = lit_cnt_inc[2:0];
                        if (lit_done)
                        begin
                            mode_next    = MODE_IDLE;
                            lit_cnt_next = 3'd0;
                        end
                        else if (end_of_text)
                        begin
                            mode_next   = MODE_IDLE;
                            halted_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    mode_next   = idle_mode;
                    halted_next = idle_halt;
                    if (idle_take_start)
                    begin
                        start_next = pos_reg;
                    end
                    if (idle_take_lit)
                    begin
                        lit_kind_next = idle_lit_kind;
                        lit_cnt_next  = 3'd1;
                    end
                end
            endcase
        end

        // The final byte of a document resets the scan.
        if (end_of_text)
        begin
            pos_next     = '0;
            mode_next    = MODE_IDLE;
            lit_cnt_next = 3'd0;
            halted_next  = 1'b0;
        end
        else if (pos_reg != POS_MAX)
        begin
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // Results for the current byte.
    always_comb
    begin
        n  = 2'd0;
        r0 = '0;
        r1 = '0;
        if (!halted_reg)
        begin
            case (mode_reg)
                MODE_STRING:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        n  = 2'd1;
                        r0 = mk(TOK_STRING, start_out, p_out, ERR_NONE);
                    end
                    else if (end_of_text)
                    begin
                        n  = 2'd1;
                        r0 = mk(TOK_LBRACE, start_out, p_out, ERR_UNTERM);
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_numeric(text_byte))
                    begin
                        if (end_of_text)
                        begin
                            n  = 2'd1;
                            r0 = mk(TOK_NUMBER, start_out, p_out, ERR_NONE);
                        end
                    end
                    else
                    begin
                        n  = idle_emit ? 2'd2 : 2'd1;
                        r0 = mk(TOK_NUMBER, start_out, p_prev_out, ERR_NONE);
                        r1 = idle_tok;
                    end
                end
                MODE_LITERAL:
                begin
                    if (!lit_match)
                    begin
                        n  = 2'd1;
                        r0 = mk(TOK_LBRACE, start_out, p_out, lit_err);
                    end
                    else if (lit_done)
                    begin
                        n  = 2'd1;
                        r0 = mk(lit_tok, start_out, p_out, ERR_NONE);
                    end
                    else if (end_of_text)
                    begin
                        n  = 2'd1;
                        r0 = mk(TOK_LBRACE, start_out, p_out, ERR_UNTERM);
                    end
                end
                default:
                begin
                    n  = idle_emit ? 2'd1 : 2'd0;
                    r0 = idle_tok;
                end
            endcase
        end

        // Mark the last result of this byte.
        if (n == 2'd1)
        begin
            r0.last = 1'b1;
        end
        if (n == 2'd2)
        begin
            r1.last = 1'b1;
        end
    end

    assign push.count  = go ? n : 2'd0;
    assign push.first  = r0;
    assign push.second = r1;

    // Scanner state registers, updated on each processed byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            start_reg    <= '0;
            lit_kind_reg <= LIT_TRUE;
            lit_cnt_reg  <= 3'd0;
            halted_reg   <= 1'b0;
        end
        else if (go)
        begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            start_reg    <= start_next;
            lit_kind_reg <= lit_kind_next;
            lit_cnt_reg  <= lit_cnt_next;
            halted_reg   <= halted_next;
        end
    end

`ifndef SYNTHESIS
    // Only a number ended by another token-producing byte yields two results.
    a_two_only_from_number: assert property (@(posedge clk) disable iff (!rst_n)
        (go && n == 2'd2) |-> (mode_reg == MODE_NUMBER))
        else $error("two results from a byte outside number mode");

    // A halted scanner produces nothing.
    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (go && halted_reg) |-> (n == 2'd0))
        else $error("result produced while halted after an error");

    // The final byte of a document returns the scanner to its starting point.
    a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (go && end_of_text) |=> (pos_reg == '0 && !halted_reg && mode_reg == MODE_IDLE))
        else $error("scanner not restarted after end of text");

    // Position counts up by one per byte until it saturates.
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (go && !end_of_text && pos_reg != POS_MAX) |=> (pos_reg == $past(pos_reg) + 1'b1))
        else $error("byte position did not advance");
`endif

endmodule

FILE: rtl/jts_out_fifo.sv
// Result queue: takes up to two results per cycle and delivers one per cycle while head_ready is high.
// Depends on jts_pkg for the result types and queue depth.
`timescale 1ns / 1ps

module jts_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  jts_pkg::push_t  push,
    output logic            room,
    output logic            head_valid,
    input  logic            head_ready,
    output jts_pkg::token_t head
);

    import jts_pkg::*;

    token_t                mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg,  count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_second;
    logic                  pop;

    assign head_valid    = (count_reg != '0);
    assign head          = mem[rd_ptr_reg];
    assign pop           = head_valid && head_ready;
    assign room          = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign wr_ptr_second = wr_ptr_reg + 1'b1;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes; the second slot follows the first.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_second] <= push.second;
        end
    end

`ifndef SYNTHESIS
    // Results arrive only while there is space for a full pair.
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room)
        else $error("result pushed into a full queue");

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue fill count overflow");

    // A waiting result stays offered and unchanged until it is taken.
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !head_ready) |=> (head_valid && $stable(head)))
        else $error("waiting result changed before it was taken");
`endif

endmodule

FILE: rtl/json_token_scanner_top.sv
// Streaming JSON token scanner, top level: input hold register, scanner and result queue.
// Depends on jts_pkg, jts_scan_core and jts_out_fifo.
// Timing: a byte is captured in the hold register when its request is accepted, is scanned
// from there when the queue has room; its first result is then offered from the queue.
// Throughput: one byte per cycle; a byte that ends a number and gives a result of its own
// gives two results, and the input stalls while the queue holds more than two results.
// Reset: rst_n is asynchronous, active low; it empties the queue and starts at position 0.
`timescale 1ns / 1ps

module json_token_scanner_top #(
    parameter int unsigned POS_WIDTH = jts_pkg::POS_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [3:0]  token_kind,
    output logic [15:0] start_pos,
    output logic [15:0] end_pos,
    output logic [2:0]  error_code,
    output logic        last_of_run
);

    import jts_pkg::*;

    logic       hold_valid_reg;
    logic [7:0] hold_byte_reg;
    logic       hold_eot_reg;
    logic       go;
    logic       room;
    push_t      push;
    token_t     head;

    // The held byte is processed when the queue can take a full pair.
    assign go         = hold_valid_reg && room;
    assign text_ready = !hold_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (text_ready)
        begin
            hold_valid_reg <= text_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            hold_byte_reg <= text_byte;
            hold_eot_reg  <= end_of_text;
        end
    end

    jts_scan_core #(
        .POS_WIDTH (POS_WIDTH)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .text_byte   (hold_byte_reg),
        .end_of_text (hold_eot_reg),
        .push        (push)
    );

    jts_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (token_valid),
        .head_ready (token_ready),
        .head       (head)
    );

    assign token_kind  = head.kind;
    assign start_pos   = head.start_pos;
    assign end_pos     = head.end_pos;
    assign error_code  = head.err;
    assign last_of_run = head.last;

endmodule
